[design/stack_calculator_engine_macros.svh]
// Assertion macros shared by the stack calculator modules
`ifndef STACK_CALCULATOR_ENGINE_MACROS_SVH
`define STACK_CALCULATOR_ENGINE_MACROS_SVH

// check that an antecedent implies a consequent in the same cycle
`define SCE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check that an antecedent implies a consequent in the next cycle
`define SCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sce_pkg.sv]
// Package with types and constants for the stack calculator
`default_nettype none
package sce_pkg;
  localparam int unsigned StackDepthDef = 1024;
  localparam int unsigned WordW = 32;
  localparam int unsigned IdxW = 10;
  localparam int unsigned DepthW = 11;
  localparam int unsigned StatW = 3;
  localparam int unsigned CmdW = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH = 3'd0, CMD_POP = 3'd1, CMD_PEEK_TOP = 3'd2, CMD_PEEK_BOT = 3'd3,
    CMD_ADD = 3'd4, CMD_SUB = 3'd5, CMD_MUL = 3'd6, CMD_DIV = 3'd7
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK = 3'd0, ST_FEW = 3'd1, ST_RANGE = 3'd2, ST_DIV0 = 3'd3, ST_FULL = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_B, S_WAIT_B, S_EXEC, S_MUL, S_DIV, S_DIV_FIX, S_WRITE, S_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic ram_rd;
    logic [1:0] rd_sel;    // 0 top, 1 second, 2 peek top, 3 peek bottom
    logic cap_a;
    logic cap_b;
    logic cap_peek;
    logic ram_wr_push;
    logic ram_wr_res;
    logic do_alu;
    logic do_mul;
    logic div_start;
    logic div_step;
    logic div_fix;
    logic [1:0] cnt_op;    // 0 hold, 1 inc, 2 dec, 3 dec two
    logic set_out;
    logic [StatW-1:0] st;
    logic res_zero;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic full;
    logic empty;
    logic few;
    logic idx_bad;
    logic a_zero;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

[design/sce_ram.sv]
// Generic single-port RAM with registered read
`default_nettype none
module sce_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule
`default_nettype wire

[design/sce_ctrl.sv]
// Controller state machine for the stack calculator
`default_nettype none
`include "stack_calculator_engine_macros.svh"
module sce_ctrl import sce_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_fire_i,
  input  wire logic  out_free_i,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o,
  output logic       busy_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_fire_i) state_d = S_RD_A;
      S_RD_A: begin
        unique case (cmd_e'(stat_i.cmd))
          CMD_PUSH:     state_d = S_DONE;
          CMD_POP:      state_d = stat_i.empty ? S_DONE : S_RD_B;
          CMD_PEEK_TOP,
          CMD_PEEK_BOT: state_d = stat_i.idx_bad ? S_DONE : S_RD_B;
          default:      state_d = stat_i.few ? S_DONE : S_RD_B;
        endcase
      end
      S_RD_B: begin
        if (stat_i.cmd == CMD_POP || stat_i.cmd == CMD_PEEK_TOP ||
            stat_i.cmd == CMD_PEEK_BOT) begin
          state_d = S_DONE;
        end else begin
          state_d = S_WAIT_B;
        end
      end
      S_WAIT_B:  state_d = S_EXEC;
      S_EXEC: begin
        priority if (stat_i.cmd == CMD_MUL) state_d = S_MUL;
        else if (stat_i.cmd == CMD_DIV) state_d = stat_i.a_zero ? S_DONE : S_DIV;
        else state_d = S_WRITE;
      end
      S_MUL:     state_d = S_WRITE;
      S_DIV:     if (stat_i.div_done) state_d = S_DIV_FIX;
      S_DIV_FIX: state_d = S_WRITE;
      S_WRITE:   state_d = S_DONE;
      S_DONE:    if (out_free_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.st = ST_OK;
    unique case (state_q)
      S_IDLE: ctrl_o.load_in = in_fire_i;
      S_RD_A: begin
        unique case (cmd_e'(stat_i.cmd))
          CMD_PUSH: begin
            ctrl_o.set_out = 1'b1;
            ctrl_o.res_zero = 1'b1;
            if (stat_i.full) begin
              ctrl_o.st = ST_FULL;
            end else begin
              ctrl_o.ram_wr_push = 1'b1;
              ctrl_o.cnt_op = 2'd1;
            end
          end
          CMD_POP: begin
            if (stat_i.empty) begin
              ctrl_o.set_out = 1'b1;
              ctrl_o.res_zero = 1'b1;
              ctrl_o.st = ST_FEW;
            end else begin
              ctrl_o.ram_rd = 1'b1;
              ctrl_o.rd_sel = 2'd0;
              ctrl_o.cnt_op = 2'd2;
            end
          end
          CMD_PEEK_TOP, CMD_PEEK_BOT: begin
            if (stat_i.idx_bad) begin
              ctrl_o.set_out = 1'b1;
              ctrl_o.res_zero = 1'b1;
              ctrl_o.st = ST_RANGE;
            end else begin
              ctrl_o.ram_rd = 1'b1;
              ctrl_o.rd_sel = (stat_i.cmd == CMD_PEEK_TOP) ? 2'd2 : 2'd3;
            end
          end
          default: begin
            if (stat_i.few) begin
              ctrl_o.set_out = 1'b1;
              ctrl_o.res_zero = 1'b1;
              ctrl_o.st = ST_FEW;
            end else begin
              ctrl_o.ram_rd = 1'b1;
              ctrl_o.rd_sel = 2'd0;
            end
          end
        endcase
      end
      S_RD_B: begin
        if (stat_i.cmd == CMD_POP || stat_i.cmd == CMD_PEEK_TOP ||
            stat_i.cmd == CMD_PEEK_BOT) begin
          ctrl_o.cap_peek = 1'b1;
          ctrl_o.set_out = 1'b1;
        end else begin
          ctrl_o.cap_a = 1'b1;
          ctrl_o.ram_rd = 1'b1;
          ctrl_o.rd_sel = 2'd1;
        end
      end
      S_WAIT_B: ctrl_o.cap_b = 1'b1;
      S_EXEC: begin
        ctrl_o.cnt_op = 2'd3;
        priority if (stat_i.cmd == CMD_MUL) ctrl_o.do_mul = 1'b1;
        else if (stat_i.cmd == CMD_DIV) begin
          if (stat_i.a_zero) begin
            ctrl_o.set_out = 1'b1;
            ctrl_o.res_zero = 1'b1;
            ctrl_o.st = ST_DIV0;
          end else begin
            ctrl_o.div_start = 1'b1;
          end
        end else ctrl_o.do_alu = 1'b1;
      end
      S_DIV:     ctrl_o.div_step = 1'b1;
      S_DIV_FIX: ctrl_o.div_fix = 1'b1;
      S_WRITE: begin
        ctrl_o.ram_wr_res = 1'b1;
        ctrl_o.cnt_op = 2'd1;
        ctrl_o.set_out = 1'b1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  `SCE_ASSERT_NEXT(a_start, clk_i, rst_ni, (state_q == S_IDLE) && in_fire_i,
                   state_q == S_RD_A, "accepted item did not start")
  `SCE_ASSERT_IMPL(a_wr_one, clk_i, rst_ni, 1'b1,
                   !(ctrl_o.ram_wr_push && ctrl_o.ram_wr_res), "double RAM write")
  `SCE_ASSERT_IMPL(a_rd_wr, clk_i, rst_ni, ctrl_o.ram_rd,
                   !(ctrl_o.ram_wr_push || ctrl_o.ram_wr_res), "read and write together")
  `SCE_ASSERT_IMPL(a_busy_in, clk_i, rst_ni, state_q != S_IDLE, !ctrl_o.load_in,
                   "item loaded while busy")
endmodule
`default_nettype wire

[design/sce_dp.sv]
// Datapath for the stack calculator: stack RAM, count, ALU and divider
`default_nettype none
`include "stack_calculator_engine_macros.svh"
module sce_dp import sce_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_t             ctrl_i,
  input  wire logic [CmdW-1:0]   cmd_i,
  input  wire logic [WordW-1:0]  push_value_i,
  input  wire logic [IdxW-1:0]   peek_index_i,
  input  wire logic              out_take_i,
  output stat_t                  stat_o,
  output logic                   out_valid_o,
  output logic [WordW-1:0]       result_value_o,
  output logic [StatW-1:0]       status_o,
  output logic [DepthW-1:0]      depth_now_o
);
  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam int unsigned DivCntW = $clog2(WordW + 1);

  logic [CmdW-1:0]  cmd_q;
  logic [WordW-1:0] pv_q;
  logic [IdxW-1:0]  idx_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] a_q, b_q, res_q, res_d;
  logic             out_valid_q;
  logic [StatW-1:0] st_q;
  logic [WordW-1:0] ov_q;

  // divider state
  logic [WordW-1:0] quo_q, quo_d, dvs_q, dvs_d;
  logic [WordW:0]   rem_q, rem_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic             neg_q, neg_d;

  logic [WordW-1:0] rdata;
  logic [AddrW-1:0] addr;
  logic [CntW-1:0]  idx_ext;
  logic [CntW-1:0]  rd_pos;
  logic             we;
  logic [WordW-1:0] wdata;

  assign idx_ext = CntW'({{(32-IdxW){1'b0}}, idx_q});

  always_comb begin
    unique case (ctrl_i.rd_sel)
      2'd0:    rd_pos = cnt_q - CntW'(1);
      2'd1:    rd_pos = cnt_q - CntW'(2);
      2'd2:    rd_pos = cnt_q - CntW'(1) - idx_ext;
      default: rd_pos = idx_ext;
    endcase
    if (ctrl_i.ram_wr_push) begin
      addr = cnt_q[AddrW-1:0];
    end else if (ctrl_i.ram_wr_res) begin
      addr = cnt_q[AddrW-1:0];
    end else begin
      addr = rd_pos[AddrW-1:0];
    end
    we = ctrl_i.ram_wr_push | ctrl_i.ram_wr_res;
    wdata = ctrl_i.ram_wr_push ? pv_q : res_q;
  end

  sce_ram #(.Width(WordW), .Depth(StackDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .re_i    (ctrl_i.ram_rd),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    unique case (ctrl_i.cnt_op)
      2'd1:    cnt_d = cnt_q + CntW'(1);
      2'd2:    cnt_d = cnt_q - CntW'(1);
      2'd3:    cnt_d = cnt_q - CntW'(2);
      default: cnt_d = cnt_q;
    endcase
  end

  // divider: unsigned restoring on magnitudes, then floor correction
  logic [WordW-1:0] b_mag, a_mag;
  logic [WordW:0]   trial;
  logic [WordW:0]   shifted;
  assign b_mag = b_q[WordW-1] ? (~b_q + WordW'(1)) : b_q;
  assign a_mag = a_q[WordW-1] ? (~a_q + WordW'(1)) : a_q;
  assign shifted = {rem_q[WordW-1:0], quo_q[WordW-1]};
  assign trial = shifted - {1'b0, dvs_q};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    dcnt_d = dcnt_q;
    neg_d = neg_q;
    if (ctrl_i.div_start) begin
      quo_d = b_mag;
      rem_d = '0;
      dvs_d = a_mag;
      dcnt_d = DivCntW'(WordW);
      neg_d = b_q[WordW-1] ^ a_q[WordW-1];
    end else if (ctrl_i.div_step && dcnt_q != '0) begin
      if (!trial[WordW]) begin
        rem_d = trial;
        quo_d = {quo_q[WordW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[WordW-2:0], 1'b0};
      end
      dcnt_d = dcnt_q - DivCntW'(1);
    end
  end

  logic [WordW-1:0] q_signed;
  assign q_signed = neg_q ? (~quo_q + WordW'(1)) : quo_q;

  logic [2*WordW-1:0] prod;
  assign prod = a_q * b_q;

  always_comb begin
    res_d = res_q;
    if (ctrl_i.do_alu) begin
      res_d = (cmd_q == CMD_ADD) ? (b_q + a_q) : (b_q - a_q);
    end else if (ctrl_i.do_mul) begin
      res_d = prod[WordW-1:0];
    end else if (ctrl_i.div_fix) begin
      res_d = (neg_q && rem_q != '0) ? (q_signed - WordW'(1)) : q_signed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      pv_q <= push_value_i;
      idx_q <= peek_index_i;
    end
    if (ctrl_i.cap_a) a_q <= rdata;
    if (ctrl_i.cap_b) b_q <= rdata;
    res_q <= res_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
    if (ctrl_i.set_out) begin
      ov_q <= ctrl_i.res_zero ? '0 : (ctrl_i.cap_peek ? rdata : res_q);
      st_q <= ctrl_i.st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      cmd_q <= CMD_PUSH;
      dcnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      dcnt_q <= dcnt_d;
      if (ctrl_i.load_in) cmd_q <= cmd_i;
      if (ctrl_i.set_out) out_valid_q <= 1'b1;
      else if (out_take_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.cmd = cmd_q;
  assign stat_o.full = (cnt_q >= CntW'(StackDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.few = (cnt_q < CntW'(2));
  assign stat_o.idx_bad = (idx_ext >= cnt_q) || (32'(idx_q) >= 32'(StackDepth));
  assign stat_o.a_zero = (a_q == '0);
  assign stat_o.div_done = (dcnt_q == '0);

  assign out_valid_o = out_valid_q;
  assign result_value_o = ov_q;
  assign status_o = st_q;
  assign depth_now_o = DepthW'(cnt_q);

  `SCE_ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(StackDepth),
                   "stack count beyond depth")
  `SCE_ASSERT_IMPL(a_push_room, clk_i, rst_ni, ctrl_i.ram_wr_push,
                   cnt_q < CntW'(StackDepth), "push into full stack")
  `SCE_ASSERT_NEXT(a_div_prog, clk_i, rst_ni, ctrl_i.div_step && dcnt_q != '0,
                   dcnt_q == $past(dcnt_q) - DivCntW'(1), "divider stalled")
endmodule
`default_nettype wire

[design/stack_calculator_engine.sv]
// Top level of the stack calculator engine
// Each input item carries one command and yields exactly one result item.
// Divide uses the one-bit-per-cycle restoring divider. The stack lives in a
// single-port RAM with registered read, so the two operands of an arithmetic
// command are fetched by two reads, one after the other. One item is in work
// at a time; a new item is taken once the previous result has been handed off.
`default_nettype none
module stack_calculator_engine import sce_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] cmd, [34:3] push_value, [44:35] peek_index, [47:45] zero
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] result_value, [34:32] status, [45:35] depth_now, [47:46] zero
  output logic [47:0]      m_axis_tdata
);
  ctrl_t ctrl;
  stat_t stat;
  logic busy;
  logic in_fire, out_take;
  logic [WordW-1:0] rv;
  logic [StatW-1:0] st;
  logic [DepthW-1:0] dn;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;

  sce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (!m_axis_tvalid || m_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  sce_dp #(.StackDepth(STACK_DEPTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cmd_i          (s_axis_tdata[2:0]),
    .push_value_i   (s_axis_tdata[34:3]),
    .peek_index_i   (s_axis_tdata[44:35]),
    .out_take_i     (out_take),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid),
    .result_value_o (rv),
    .status_o       (st),
    .depth_now_o    (dn)
  );

  assign m_axis_tdata = {2'b00, dn, st, rv};
endmodule
`default_nettype wire
